// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL, included by serial_duty_command_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SDCP_CHECK(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SDCP_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/sdcp_pkg.sv -----
`default_nettype none

package sdcp_pkg;

  localparam logic [9:0] FULL_SCALE_RST = 10'd136;
  localparam logic [6:0] PCT_ONE_RST    = 7'd75;
  localparam logic [6:0] PCT_TWO_RST    = 7'd25;
  localparam logic [9:0] PCT_LIMIT      = 10'd100;
  localparam logic [1:0] MAX_DIGITS     = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CMD_ONE   = 8'h6F;
  localparam logic [7:0] CMD_TWO   = 8'h74;
  localparam logic [7:0] CMD_BOTH  = 8'h62;

  // Division by 100 is a multiplication by ceil(2^24 / 100) followed by a
  // shift; it is exact for every product of a 10-bit scale and a percentage.
  localparam int PROD_W      = 17;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;

  typedef enum logic [2:0] {
    ST_DIGIT   = 3'd0,
    ST_REJECT  = 3'd1,
    ST_OVER    = 3'd2,
    ST_UPDATED = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] pct_one;
    logic [6:0] pct_two;
  } parse_res_t;

endpackage

`default_nettype wire

// ----- src/serial_duty_command_parser.sv -----
// Throughput: one transaction per cycle; the whole pipeline holds while the result is stalled.
// The stages are input register, parser, scale product and division by 100.
// Reset (rst_n, synchronous, active low) sets full_scale to 136, the duties to 75 and 25
// percent, empties the digit buffer and clears every valid flag.
`default_nettype none
`include "assert_macros.svh"

module serial_duty_command_parser (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output wire       in_stall,
  input  wire [7:0] in_rx_byte,
  output wire       out_valid,
  input  wire       out_stall,
  output wire [2:0] out_status,
  output wire [6:0] out_duty_one_percent,
  output wire [6:0] out_duty_two_percent,
  output wire [9:0] out_compare_one,
  output wire [9:0] out_compare_two,
  input  wire       cfg_wr_en,
  input  wire [9:0] cfg_wr_data
);

  logic                 adv;
  logic [9:0]           full_scale_r;
  logic                 in_v_r, in_v_nxt;
  logic [7:0]           in_byte_r;
  logic                 par_v_r;
  logic                 mid_v_r;
  logic                 out_v_r;
  sdcp_pkg::parse_res_t par_res;
  sdcp_pkg::parse_res_t mid_r;
  sdcp_pkg::parse_res_t out_r;
  logic [9:0]           cmp_one;
  logic [9:0]           cmp_two;

  assign adv      = !(out_v_r && out_stall);
  assign in_stall = !adv;
  assign in_v_nxt = in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= sdcp_pkg::FULL_SCALE_RST;
    end else if (cfg_wr_en) begin
      full_scale_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      par_v_r <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      in_v_r  <= in_v_nxt;
      par_v_r <= in_v_r;
      mid_v_r <= par_v_r;
      out_v_r <= mid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_byte_r <= in_rx_byte;
      mid_r     <= par_res;
      out_r     <= mid_r;
    end
  end

  sdcp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .byte_valid (in_v_r),
    .rx_byte    (in_byte_r),
    .res        (par_res)
  );

  sdcp_scale u_scale_one (
    .clk        (clk),
    .adv        (adv),
    .full_scale (full_scale_r),
    .pct        (par_res.pct_one),
    .compare    (cmp_one)
  );

  sdcp_scale u_scale_two (
    .clk        (clk),
    .adv        (adv),
    .full_scale (full_scale_r),
    .pct        (par_res.pct_two),
    .compare    (cmp_two)
  );

  assign out_valid            = out_v_r;
  assign out_status           = out_r.status;
  assign out_duty_one_percent = out_r.pct_one;
  assign out_duty_two_percent = out_r.pct_two;
  assign out_compare_one      = cmp_one;
  assign out_compare_two      = cmp_two;

  `SDCP_IMPLIES(a_duty_range, out_v_r,
                (out_r.pct_one <= 7'd100) && (out_r.pct_two <= 7'd100),
                "duty percentage above 100")
  `SDCP_IMPLIES(a_cmp_one_bound, out_v_r, cmp_one <= full_scale_r,
                "channel one compare exceeds full scale")
  `SDCP_IMPLIES(a_cmp_two_bound, out_v_r, cmp_two <= full_scale_r,
                "channel two compare exceeds full scale")
  `SDCP_CHECK(a_hold_on_stall, !(out_v_r && out_stall) || in_stall,
              "pipeline advanced under a stalled result")

endmodule

`default_nettype wire

// ----- src/sdcp_parse.sv -----
`default_nettype none

module sdcp_parse (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    adv,
  input  wire                    byte_valid,
  input  wire [7:0]              rx_byte,
  output sdcp_pkg::parse_res_t   res
);

  logic [9:0]           digit_value_r, digit_value_nxt;
  logic [1:0]           digit_count_r, digit_count_nxt;
  logic [6:0]           pct_one_r, pct_one_nxt;
  logic [6:0]           pct_two_r, pct_two_nxt;
  sdcp_pkg::parse_res_t res_r, res_nxt;

  logic                 is_cmd;
  logic                 is_digit;
  logic [3:0]           digit;
  logic [9:0]           acc;

  always_comb begin
    is_cmd   = rx_byte inside {sdcp_pkg::CMD_ONE, sdcp_pkg::CMD_TWO, sdcp_pkg::CMD_BOTH};
    is_digit = rx_byte inside {[sdcp_pkg::CHAR_ZERO:sdcp_pkg::CHAR_NINE]};
    digit    = 4'(rx_byte - sdcp_pkg::CHAR_ZERO);
    acc      = digit_value_r * 10'd10 + {6'd0, digit};

    digit_value_nxt = digit_value_r;
    digit_count_nxt = digit_count_r;
    pct_one_nxt     = pct_one_r;
    pct_two_nxt     = pct_two_r;
    res_nxt.status  = sdcp_pkg::ST_REJECT;

    if (is_cmd) begin
      if (digit_value_r > sdcp_pkg::PCT_LIMIT) begin
        res_nxt.status = sdcp_pkg::ST_OVER;
      end else begin
        if (rx_byte != sdcp_pkg::CMD_TWO) begin
          pct_one_nxt = digit_value_r[6:0];
        end
        if (rx_byte != sdcp_pkg::CMD_ONE) begin
          pct_two_nxt = digit_value_r[6:0];
        end
        res_nxt.status = sdcp_pkg::ST_UPDATED;
      end
      digit_value_nxt = 10'd0;
      digit_count_nxt = 2'd0;
    end else if (is_digit) begin
      if (digit_count_r < sdcp_pkg::MAX_DIGITS) begin
        digit_value_nxt = acc;
        digit_count_nxt = digit_count_r + 2'd1;
        res_nxt.status  = sdcp_pkg::ST_DIGIT;
      end else begin
        res_nxt.status = sdcp_pkg::ST_FULL;
      end
    end

    res_nxt.pct_one = pct_one_nxt;
    res_nxt.pct_two = pct_two_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_value_r <= 10'd0;
      digit_count_r <= 2'd0;
      pct_one_r     <= sdcp_pkg::PCT_ONE_RST;
      pct_two_r     <= sdcp_pkg::PCT_TWO_RST;
    end else if (adv && byte_valid) begin
      digit_value_r <= digit_value_nxt;
      digit_count_r <= digit_count_nxt;
      pct_one_r     <= pct_one_nxt;
      pct_two_r     <= pct_two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- src/sdcp_scale.sv -----
`default_nettype none

module sdcp_scale (
  input  wire       clk,
  input  wire       adv,
  input  wire [9:0] full_scale,
  input  wire [6:0] pct,
  output wire [9:0] compare
);

  logic [sdcp_pkg::PROD_W-1:0]                     prod_r, prod_nxt;
  logic [sdcp_pkg::PROD_W+sdcp_pkg::RECIP_W-1:0]   scaled;
  logic [9:0]                                      cmp_r, cmp_nxt;

  always_comb begin
    prod_nxt = {7'd0, full_scale} * {10'd0, pct};
    scaled   = {{sdcp_pkg::RECIP_W{1'b0}}, prod_r} *
               {{sdcp_pkg::PROD_W{1'b0}}, sdcp_pkg::RECIP_100};
    cmp_nxt  = scaled[sdcp_pkg::RECIP_SHIFT +: 10];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      cmp_r  <= cmp_nxt;
    end
  end

  assign compare = cmp_r;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_COUNT    = 6;
  localparam int ITEMS_PER_PHASE = 285;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    sdcp_pkg::status_t status;
    logic [6:0]        duty_one;
    logic [6:0]        duty_two;
    logic [9:0]        cmp_one;
    logic [9:0]        cmp_two;
  } duty_report_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_status;
  logic [6:0] out_duty_one_percent;
  logic [6:0] out_duty_two_percent;
  logic [9:0] out_compare_one;
  logic [9:0] out_compare_two;
  logic       cfg_wr_en = 1'b0;
  logic [9:0] cfg_wr_data = 10'd0;

  logic [7:0]   rx_byte_q[$];
  duty_report_t duty_report_q[$];
  int unsigned  cycle_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  accepted_count = 0;

  logic [9:0] digit_acc;
  logic [1:0] digit_total;
  logic [6:0] pct_one_now;
  logic [6:0] pct_two_now;
  logic [9:0] scale_now;

  serial_duty_command_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_duty_one_percent (out_duty_one_percent),
    .out_duty_two_percent (out_duty_two_percent),
    .out_compare_one      (out_compare_one),
    .out_compare_two      (out_compare_two),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[serial_duty_command_parser] ERROR");
      $finish;
    end
  end

  function automatic logic [9:0] scaled_compare(input logic [6:0] pct);
    int unsigned product;
    product = int'(scale_now) * int'(pct);
    return 10'(product / 100);
  endfunction

  function automatic duty_report_t parse_duty_byte(input logic [7:0] rx);
    duty_report_t r;
    if (rx == sdcp_pkg::CMD_ONE || rx == sdcp_pkg::CMD_TWO || rx == sdcp_pkg::CMD_BOTH) begin
      if (digit_acc > sdcp_pkg::PCT_LIMIT) begin
        r.status = sdcp_pkg::ST_OVER;
      end else begin
        if (rx != sdcp_pkg::CMD_TWO) pct_one_now = digit_acc[6:0];
        if (rx != sdcp_pkg::CMD_ONE) pct_two_now = digit_acc[6:0];
        r.status = sdcp_pkg::ST_UPDATED;
      end
      digit_acc = 10'd0;
      digit_total = 2'd0;
    end else if (rx >= sdcp_pkg::CHAR_ZERO && rx <= sdcp_pkg::CHAR_NINE) begin
      if (digit_total < sdcp_pkg::MAX_DIGITS) begin
        digit_acc = 10'(int'(digit_acc) * 10 + int'(rx - sdcp_pkg::CHAR_ZERO));
        digit_total = digit_total + 2'd1;
        r.status = sdcp_pkg::ST_DIGIT;
      end else begin
        r.status = sdcp_pkg::ST_FULL;
      end
    end else begin
      r.status = sdcp_pkg::ST_REJECT;
    end
    r.duty_one = pct_one_now;
    r.duty_two = pct_two_now;
    r.cmp_one = scaled_compare(pct_one_now);
    r.cmp_two = scaled_compare(pct_two_now);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s at cycle %0d: got %0d, expected %0d",
             what, cycle_count, got, want);
    mismatch_count++;
  endtask

  // Sender: bursts of random length, random gaps, and now and then a pause
  // until every outstanding result has been returned.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          drain_hold = 1'b0;

  always @(posedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = in_valid;
    nxt_byte = in_rx_byte;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        duty_report_q.push_back(parse_duty_byte(in_rx_byte));
        accepted_count++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (drain_hold) begin
          if (duty_report_q.size() == 0) drain_hold = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (rx_byte_q.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_byte = rx_byte_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            drain_hold = ($urandom_range(0, 39) == 0);
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_rx_byte <= nxt_byte;
  end

  // Receiver: a stall pattern that changes mode now and then, with
  // at least one long hold-off so that the pipeline fills and stalls its input.
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if ((!long_hold_done && accepted_count >= 300) ||
                   $urandom_range(0, 1999) == 0) begin
        long_hold_done = 1'b1;
        hold_left = $urandom_range(60, 120);
        nxt_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 64);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:  nxt_stall = 1'b0;
          STALL_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: nxt_stall = ($urandom_range(0, 3) != 0);
          default:     nxt_stall = cycle_count[2];
        endcase
      end
    end
    out_stall <= nxt_stall;
  end

  always @(posedge clk) begin
    duty_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (duty_report_q.size() == 0) begin
        report_mismatch("unexpected transaction status", int'(out_status), -1);
      end else begin
        want = duty_report_q.pop_front();
        if (out_status != want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_duty_one_percent != want.duty_one)
          report_mismatch("duty_one_percent", int'(out_duty_one_percent),
                          int'(want.duty_one));
        if (out_duty_two_percent != want.duty_two)
          report_mismatch("duty_two_percent", int'(out_duty_two_percent),
                          int'(want.duty_two));
        if (out_compare_one != want.cmp_one)
          report_mismatch("compare_one", int'(out_compare_one), int'(want.cmp_one));
        if (out_compare_two != want.cmp_two)
          report_mismatch("compare_two", int'(out_compare_two), int'(want.cmp_two));
      end
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_byte_q.push_back(s[i]);
  endtask

  // One command: a number of zero to six digits, sometimes with stray bytes
  // in between and sometimes without its closing letter.
  function automatic int push_command_sequence();
    int unsigned kind;
    int unsigned value;
    int unsigned width;
    int          counted;
    logic [7:0]  cmd;
    counted = 0;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       cmd = sdcp_pkg::CMD_ONE;
      1:       cmd = sdcp_pkg::CMD_TWO;
      default: cmd = sdcp_pkg::CMD_BOTH;
    endcase
    if (kind < 60) begin
      value = $urandom_range(0, 100);
      width = (value >= 100) ? 3 : (value >= 10) ? 2 : 1;
      width = $urandom_range(width, 3);
    end else if (kind < 82) begin
      width = $urandom_range(0, 3);
      value = $urandom_range(0, 999);
    end else begin
      width = $urandom_range(4, 6);
      value = $urandom_range(0, 999999);
    end
    for (int i = int'(width) - 1; i >= 0; i--) begin
      if ($urandom_range(0, 14) == 0) rx_byte_q.push_back(8'($urandom_range(0, 255)));
      rx_byte_q.push_back(sdcp_pkg::CHAR_ZERO + 8'((value / (10 ** i)) % 10));
      counted++;
    end
    if ($urandom_range(0, 9) != 0) begin
      rx_byte_q.push_back(cmd);
      counted++;
    end
    return counted;
  endfunction

  task automatic wait_idle();
    do begin
      while (rx_byte_q.size() != 0 || in_valid || duty_report_q.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (rx_byte_q.size() != 0 || in_valid || duty_report_q.size() != 0);
  endtask

  task automatic write_full_scale(input logic [9:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 10'($urandom);
    scale_now = value;
  endtask

  initial begin
    int          counted;
    logic [9:0]  next_scale;
    digit_acc = 10'd0;
    digit_total = 2'd0;
    pct_one_now = sdcp_pkg::PCT_ONE_RST;
    pct_two_now = sdcp_pkg::PCT_TWO_RST;
    scale_now = sdcp_pkg::FULL_SCALE_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    push_text("100o");
    push_text("t");
    push_text("101b");
    push_text("9999");
    push_text("b");
    rx_byte_q.push_back(8'h00);
    rx_byte_q.push_back(8'hFF);
    push_text("5");
    rx_byte_q.push_back(8'h00);
    rx_byte_q.push_back(8'hFF);
    push_text("/:0t");
    push_text("42o");
    wait_idle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       next_scale = 10'd1023;
        1:       next_scale = 10'd0;
        2:       next_scale = 10'd1;
        default: next_scale = 10'($urandom_range(2, 1022));
      endcase
      write_full_scale(next_scale);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) counted += push_command_sequence();
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("[serial_duty_command_parser] OK");
    end else begin
      $display("[serial_duty_command_parser] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/sdcp_pkg.sv
src/sdcp_parse.sv
src/sdcp_scale.sv
src/serial_duty_command_parser.sv
sim/testbench.sv
